>>> src/rcht_pkg.sv
// ----------------------------------------------------------------------------
// rcht_pkg: shared types and constants for the chained hash table
// Command codes, status codes, port payload structs and the queue entry.
// ----------------------------------------------------------------------------
package rcht_pkg;

  localparam int unsigned SLOT_COUNT_DEF   = 256;
  localparam int unsigned BUCKET_COUNT_DEF = 256;
  localparam int unsigned KEY_BITS_DEF     = 64;
  localparam int unsigned REFS_W           = 16;
  localparam int unsigned QUEUE_DEPTH      = 2;
  localparam logic [3:0]  CAP_RESET        = 4'd8;
  localparam logic [3:0]  MAX_PAYLOAD      = 4'd8;

  typedef enum logic [2:0] {
    CMD_FIND       = 3'd0,
    CMD_PUT        = 3'd1,
    CMD_RELEASE    = 3'd2,
    CMD_INVALIDATE = 3'd3,
    CMD_CLEAR      = 3'd4,
    CMD_QUERY      = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_NOT_FOUND = 3'd1,
    STS_INSERTED  = 3'd2,
    STS_FULL      = 3'd3,
    STS_BAD       = 3'd4,
    STS_HELD      = 3'd5,
    STS_REMOVED   = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    OP_FIND  = 3'd0,
    OP_PUT   = 3'd1,
    OP_REL   = 3'd2,
    OP_QUERY = 3'd3,
    OP_BAD   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    REL_RELEASE = 2'd0,
    REL_INVAL   = 2'd1,
    REL_CLEAR   = 2'd2
  } rel_e;

  // Slot flag bits.
  localparam logic [1:0] FLAG_INUSE   = 2'b01;
  localparam logic [1:0] FLAG_INVALID = 2'b10;

  typedef struct packed {
    logic [2:0]  command;
    logic [63:0] key;
    logic [7:0]  slot;
    logic [63:0] payload;
    logic [3:0]  payload_length;
  } cmd_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  result_slot;
    logic [63:0] result_payload;
    logic        entry_valid;
  } result_t;

  typedef struct packed {
    op_e         op;
    rel_e        kind;
    logic [63:0] key;
    logic [15:0] bucket;
    logic [7:0]  slot;
    logic [63:0] payload;
  } job_t;

endpackage

>>> src/rcht_front.sv
// ----------------------------------------------------------------------------
// rcht_front: command classification
// Holds the payload capacity register, checks requests, masks key and
// payload, hashes the key and builds a job for the back end.
// ----------------------------------------------------------------------------
module rcht_front import rcht_pkg::*; #(
  parameter int unsigned SLOT_COUNT   = SLOT_COUNT_DEF,
  parameter int unsigned BUCKET_COUNT = BUCKET_COUNT_DEF,
  parameter int unsigned KEY_BITS     = KEY_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_in_t    cmd_i,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_data_i,
  output job_t       job_o
);

  localparam int unsigned BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - KEY_BITS);

  logic [3:0]  cap_q;
  logic [16:0] hash_raw;
  logic [16:0] hash_fix;
  logic [16:0] slot_ext;
  logic        slot_ok;
  logic        len_ok;
  logic [63:0] pay_mask;
  logic [63:0] key_m;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_data_i;
    end
  end

  assign key_m    = cmd_i.key & KEY_MASK;
  // The low key bits stay below twice the bucket count, so one subtract folds them.
  assign hash_raw = 17'(key_m[BW-1:0]);
  assign hash_fix = (hash_raw >= 17'(BUCKET_COUNT)) ? hash_raw - 17'(BUCKET_COUNT)
                                                    : hash_raw;
  assign slot_ext = 17'(cmd_i.slot);
  assign slot_ok  = slot_ext < 17'(SLOT_COUNT);
  assign len_ok   = (cmd_i.payload_length <= cap_q) &&
                    (cmd_i.payload_length <= MAX_PAYLOAD);

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      pay_mask[b*8 +: 8] = (4'(b) < cmd_i.payload_length) ? 8'hFF : 8'h00;
    end
  end

  always_comb begin
    job_o.op      = OP_BAD;
    job_o.kind    = REL_RELEASE;
    job_o.key     = key_m;
    job_o.bucket  = hash_fix[15:0];
    job_o.slot    = 8'd0;
    job_o.payload = cmd_i.payload & pay_mask;
    case (cmd_i.command)
      CMD_FIND: job_o.op = OP_FIND;
      CMD_PUT:  job_o.op = len_ok ? OP_PUT : OP_BAD;
      CMD_RELEASE, CMD_INVALIDATE, CMD_CLEAR: begin
        job_o.slot = cmd_i.slot;
        job_o.op   = slot_ok ? OP_REL : OP_BAD;
        if (cmd_i.command == CMD_INVALIDATE) begin
          job_o.kind = REL_INVAL;
        end else if (cmd_i.command == CMD_CLEAR) begin
          job_o.kind = REL_CLEAR;
        end
      end
      CMD_QUERY: begin
        job_o.slot = cmd_i.slot;
        job_o.op   = slot_ok ? OP_QUERY : OP_BAD;
      end
      default: job_o.op = OP_BAD;
    endcase
  end

endmodule

>>> src/rcht_fifo.sv
// ----------------------------------------------------------------------------
// rcht_fifo: job queue
// Short register queue between the front and the back end.
// ----------------------------------------------------------------------------
module rcht_fifo import rcht_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  input  logic pop_i,
  output job_t data_o,
  output logic empty_o,
  output logic full_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);

  job_t          mem_q [QUEUE_DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (AW+1)'(QUEUE_DEPTH));
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

endmodule

>>> src/rcht_back.sv
// ----------------------------------------------------------------------------
// rcht_back: table engine
// Owns the slot and bucket memories and the free list, runs the clearing
// pass after reset and carries out one job at a time.
// ----------------------------------------------------------------------------
module rcht_back import rcht_pkg::*; #(
  parameter int unsigned SLOT_COUNT   = SLOT_COUNT_DEF,
  parameter int unsigned BUCKET_COUNT = BUCKET_COUNT_DEF,
  parameter int unsigned KEY_BITS     = KEY_BITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  job_t    job_i,
  input  logic    empty_i,
  output logic    pop_o,
  output logic    init_o,
  output logic    done_o,
  output result_t result_o
);

  localparam int unsigned SW   = $clog2(SLOT_COUNT);
  localparam int unsigned PW   = SW + 1;
  localparam int unsigned BW   = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int unsigned MAXC = (SLOT_COUNT > BUCKET_COUNT) ? SLOT_COUNT : BUCKET_COUNT;
  localparam int unsigned CW   = $clog2(MAXC);
  localparam logic [PW-1:0] NIL = {1'b1, {SW{1'b0}}};
  localparam logic [REFS_W-1:0] REFS_MAX = {REFS_W{1'b1}};

  typedef enum logic [9:0] {
    ST_INIT  = 10'b0000000001,
    ST_IDLE  = 10'b0000000010,
    ST_F_HD  = 10'b0000000100,
    ST_F_CHK = 10'b0000001000,
    ST_F_CMP = 10'b0000010000,
    ST_P_RD  = 10'b0000100000,
    ST_P_WR  = 10'b0001000000,
    ST_R_RD  = 10'b0010000000,
    ST_R_WR  = 10'b0100000000,
    ST_Q_RD  = 10'b1000000000
  } state_e;

  // Memories.
  logic [PW-1:0]       bh_mem    [BUCKET_COUNT];
  logic [1:0]          flags_mem [SLOT_COUNT];
  logic [REFS_W-1:0]   refs_mem  [SLOT_COUNT];
  logic [PW-1:0]       prev_mem  [SLOT_COUNT];
  logic [PW-1:0]       next_mem  [SLOT_COUNT];
  logic [BW-1:0]       bkt_mem   [SLOT_COUNT];
  logic [KEY_BITS-1:0] key_mem   [SLOT_COUNT];
  logic [63:0]         val_mem   [SLOT_COUNT];

  logic [BW-1:0] b_ra, bh_wa, bkt_rd;
  logic [SW-1:0] s_ra;
  logic [PW-1:0] bh_rd, prev_rd, next_rd;
  logic [1:0]    flags_rd;
  logic [REFS_W-1:0] refs_rd;
  logic [KEY_BITS-1:0] key_rd;
  logic [63:0]   val_rd;

  logic bh_we, flags_we, refs_we, prev_we, next_we, slot_we;
  logic [SW-1:0] flags_wa, refs_wa, prev_wa, next_wa, slot_wa;
  logic [PW-1:0] bh_wd, prev_wd, next_wd;
  logic [1:0]    flags_wd;
  logic [REFS_W-1:0] refs_wd;

  state_e state_q, state_d;
  job_t   job_q, job_d;
  logic [CW-1:0] init_q, init_d;
  logic [PW-1:0] free_q, free_d, cur_q, cur_d, old_q, old_d, n_q, n_d;
  logic [SW:0]   steps_q, steps_d;
  logic          done_q, done_d;
  result_t       res_q, res_d;

  logic [SW-1:0] head_sidx, job_sidx;
  logic [16:0]   init_ext;
  logic [REFS_W-1:0] new_refs;
  logic [15:0]   cur16, n16;

  assign head_sidx = SW'({8'd0, job_i.slot});
  assign job_sidx  = SW'({8'd0, job_q.slot});
  assign init_ext  = 17'(init_q);
  assign cur16     = 16'(cur_q[SW-1:0]);
  assign n16       = 16'(n_q[SW-1:0]);

  always_ff @(posedge clk_i) begin
    if (bh_we) bh_mem[bh_wa] <= bh_wd;
    bh_rd <= bh_mem[b_ra];
  end

  always_ff @(posedge clk_i) begin
    if (flags_we) flags_mem[flags_wa] <= flags_wd;
    flags_rd <= flags_mem[s_ra];
  end

  always_ff @(posedge clk_i) begin
    if (refs_we) refs_mem[refs_wa] <= refs_wd;
    refs_rd <= refs_mem[s_ra];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    prev_rd <= prev_mem[s_ra];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    next_rd <= next_mem[s_ra];
  end

  // Bucket, key and value are written together, only when a put allocates.
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      bkt_mem[slot_wa] <= job_q.bucket[BW-1:0];
      key_mem[slot_wa] <= job_q.key[KEY_BITS-1:0];
      val_mem[slot_wa] <= job_q.payload;
    end
    bkt_rd <= bkt_mem[s_ra];
    key_rd <= key_mem[s_ra];
    val_rd <= val_mem[s_ra];
  end

  // Count after a release: clear forces zero, a zero count stays zero.
  always_comb begin
    if (job_q.kind == REL_CLEAR || refs_rd == '0) begin
      new_refs = '0;
    end else begin
      new_refs = refs_rd - 1'b1;
    end
  end

  always_comb begin
    state_d  = state_q;
    job_d    = job_q;
    init_d   = init_q;
    free_d   = free_q;
    cur_d    = cur_q;
    old_d    = old_q;
    n_d      = n_q;
    steps_d  = steps_q;
    done_d   = 1'b0;
    res_d    = res_q;
    pop_o    = 1'b0;
    b_ra     = job_q.bucket[BW-1:0];
    s_ra     = job_sidx;
    bh_we    = 1'b0;  bh_wa    = '0; bh_wd    = NIL;
    flags_we = 1'b0;  flags_wa = '0; flags_wd = '0;
    refs_we  = 1'b0;  refs_wa  = '0; refs_wd  = '0;
    prev_we  = 1'b0;  prev_wa  = '0; prev_wd  = NIL;
    next_we  = 1'b0;  next_wa  = '0; next_wd  = NIL;
    slot_we  = 1'b0;  slot_wa  = '0;

    case (state_q)
      ST_INIT: begin
        if (init_ext < 17'(BUCKET_COUNT)) begin
          bh_we = 1'b1;
          bh_wa = init_q[BW-1:0];
        end
        if (init_ext < 17'(SLOT_COUNT)) begin
          flags_we = 1'b1; flags_wa = init_q[SW-1:0];
          refs_we  = 1'b1; refs_wa  = init_q[SW-1:0];
          prev_we  = 1'b1; prev_wa  = init_q[SW-1:0];
          next_we  = 1'b1; next_wa  = init_q[SW-1:0];
          prev_wd  = (init_q == '0) ? NIL : PW'(init_ext - 17'd1);
          next_wd  = (init_ext + 17'd1 < 17'(SLOT_COUNT)) ? PW'(init_ext + 17'd1) : NIL;
        end
        if (init_ext == 17'(MAXC - 1)) begin
          state_d = ST_IDLE;
        end else begin
          init_d = init_q + 1'b1;
        end
      end

      ST_IDLE: begin
        b_ra = job_i.bucket[BW-1:0];
        s_ra = (job_i.op == OP_PUT) ? free_q[SW-1:0] : head_sidx;
        if (!empty_i) begin
          pop_o   = 1'b1;
          job_d   = job_i;
          steps_d = '0;
          res_d   = '0;
          case (job_i.op)
            OP_FIND:  state_d = ST_F_HD;
            OP_PUT: begin
              if (free_q[SW]) begin
                done_d       = 1'b1;
                res_d.status = STS_FULL;
              end else begin
                n_d     = free_q;
                state_d = ST_P_RD;
              end
            end
            OP_REL:   state_d = ST_R_RD;
            OP_QUERY: state_d = ST_Q_RD;
            default: begin
              done_d            = 1'b1;
              res_d.status      = STS_BAD;
              res_d.result_slot = job_i.slot;
            end
          endcase
        end
      end

      ST_F_HD: begin
        cur_d   = bh_rd;
        state_d = ST_F_CHK;
      end

      ST_F_CHK: begin
        s_ra = cur_q[SW-1:0];
        if (cur_q[SW] || steps_q == (SW+1)'(SLOT_COUNT)) begin
          done_d       = 1'b1;
          res_d.status = STS_NOT_FOUND;
          state_d      = ST_IDLE;
        end else begin
          state_d = ST_F_CMP;
        end
      end

      ST_F_CMP: begin
        if (flags_rd == FLAG_INUSE && key_rd == job_q.key[KEY_BITS-1:0]) begin
          refs_we              = 1'b1;
          refs_wa              = cur_q[SW-1:0];
          refs_wd              = (refs_rd == REFS_MAX) ? refs_rd : refs_rd + 1'b1;
          done_d               = 1'b1;
          res_d.status         = STS_OK;
          res_d.result_slot    = cur16[7:0];
          res_d.result_payload = val_rd;
          state_d              = ST_IDLE;
        end else begin
          cur_d   = next_rd;
          steps_d = steps_q + 1'b1;
          state_d = ST_F_CHK;
        end
      end

      ST_P_RD: begin
        free_d   = next_rd;
        old_d    = bh_rd;
        flags_we = 1'b1; flags_wa = n_q[SW-1:0]; flags_wd = FLAG_INUSE;
        refs_we  = 1'b1; refs_wa  = n_q[SW-1:0]; refs_wd  = REFS_W'(1);
        prev_we  = 1'b1; prev_wa  = n_q[SW-1:0]; prev_wd  = NIL;
        next_we  = 1'b1; next_wa  = n_q[SW-1:0]; next_wd  = bh_rd;
        slot_we  = 1'b1; slot_wa  = n_q[SW-1:0];
        bh_we    = 1'b1; bh_wa    = job_q.bucket[BW-1:0]; bh_wd = n_q;
        state_d  = ST_P_WR;
      end

      ST_P_WR: begin
        // The old bucket head gets its back link to the new entry.
        if (!old_q[SW]) begin
          prev_we = 1'b1;
          prev_wa = old_q[SW-1:0];
          prev_wd = n_q;
        end
        done_d            = 1'b1;
        res_d.status      = STS_INSERTED;
        res_d.result_slot = n16[7:0];
        state_d           = ST_IDLE;
      end

      ST_R_RD: begin
        res_d.result_slot = job_q.slot;
        state_d           = ST_IDLE;
        if (!flags_rd[0]) begin
          done_d       = 1'b1;
          res_d.status = STS_BAD;
        end else if (new_refs != '0) begin
          refs_we  = 1'b1; refs_wa = job_sidx; refs_wd = new_refs;
          if (job_q.kind == REL_INVAL) begin
            flags_we = 1'b1; flags_wa = job_sidx; flags_wd = flags_rd | FLAG_INVALID;
          end
          done_d       = 1'b1;
          res_d.status = STS_HELD;
        end else begin
          if (!prev_rd[SW]) begin
            next_we = 1'b1; next_wa = prev_rd[SW-1:0]; next_wd = next_rd;
          end else begin
            bh_we = 1'b1; bh_wa = bkt_rd; bh_wd = next_rd;
          end
          if (!next_rd[SW]) begin
            prev_we = 1'b1; prev_wa = next_rd[SW-1:0]; prev_wd = prev_rd;
          end
          flags_we = 1'b1; flags_wa = job_sidx; flags_wd = '0;
          refs_we  = 1'b1; refs_wa  = job_sidx; refs_wd  = '0;
          old_d    = free_q;
          free_d   = PW'(job_sidx);
          state_d  = ST_R_WR;
        end
      end

      ST_R_WR: begin
        next_we      = 1'b1; next_wa = job_sidx; next_wd = old_q;
        prev_we      = 1'b1; prev_wa = job_sidx; prev_wd = NIL;
        done_d       = 1'b1;
        res_d.status = STS_REMOVED;
        state_d      = ST_IDLE;
      end

      ST_Q_RD: begin
        done_d            = 1'b1;
        res_d.status      = STS_OK;
        res_d.result_slot = job_q.slot;
        res_d.entry_valid = (flags_rd == FLAG_INUSE);
        state_d           = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      init_q  <= '0;
      free_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      free_q  <= free_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q   <= job_d;
    cur_q   <= cur_d;
    old_q   <= old_d;
    n_q     <= n_d;
    steps_q <= steps_d;
    res_q   <= res_d;
  end

  assign init_o   = (state_q == ST_INIT);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

>>> src/refcounted_chained_hash_table_top.sv
// ----------------------------------------------------------------------------
// refcounted_chained_hash_table_top: reference-counted chained hash table
// Front classifies commands into a two-entry queue; the back end walks and
// edits the bucket chains and the free list in on-chip memories.
//
//   Channel  Signals                               Direction  Transfer
//   command  start, busy, cmd_i                    in         start & !busy
//   result   done_o, result_o                      out        done_o (1 cycle)
//   config   cfg_valid_i, cfg_ready_o, cfg_data_i  in         valid & ready
//
// After reset a clearing pass sets up the chain and free-list memories; busy
// stays high during it. A find walks the bucket chain one slot per step, and
// every step waits on the registered memory read.
// busy rises when the queue is full. The receiver cannot stall; each
// result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module refcounted_chained_hash_table_top import rcht_pkg::*; #(
  parameter int unsigned SLOT_COUNT   = SLOT_COUNT_DEF,
  parameter int unsigned BUCKET_COUNT = BUCKET_COUNT_DEF,
  parameter int unsigned KEY_BITS     = KEY_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  cmd_in_t    cmd_i,
  output logic       done_o,
  output result_t    result_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [3:0] cfg_data_i
);

  job_t job_in, job_head;
  logic push, pop, empty, full, init;

  assign cfg_ready_o = 1'b1;
  assign busy        = full | init;
  assign push        = start & ~busy;

  rcht_front #(
    .SLOT_COUNT  (SLOT_COUNT),
    .BUCKET_COUNT(BUCKET_COUNT),
    .KEY_BITS    (KEY_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd_i),
    .cfg_we_i  (cfg_valid_i & cfg_ready_o),
    .cfg_data_i(cfg_data_i),
    .job_o     (job_in)
  );

  rcht_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (job_in),
    .pop_i  (pop),
    .data_o (job_head),
    .empty_o(empty),
    .full_o (full)
  );

  rcht_back #(
    .SLOT_COUNT  (SLOT_COUNT),
    .BUCKET_COUNT(BUCKET_COUNT),
    .KEY_BITS    (KEY_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .job_i   (job_head),
    .empty_i (empty),
    .pop_o   (pop),
    .init_o  (init),
    .done_o  (done_o),
    .result_o(result_o)
  );

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.status != 3'd7))
    else $error("result status out of range");

  a_valid_only_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.entry_valid) |-> (result_o.status == STS_OK))
    else $error("entry_valid set on a non-query result");

  a_insert_no_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status != STS_OK) |-> (result_o.result_payload == '0))
    else $error("payload returned without a find hit");

  a_no_result_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init |-> !done_o)
    else $error("result during the clearing pass");

endmodule
